// File: src/dqe_pkg.sv
// Shared types and constants for the double-ended queue.
`default_nettype none

package dqe_pkg;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_REAR  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_READ_ALL   = 3'd4
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_SHIFT_IN,
    CMD_LOAD_REAR,
    CMD_ROTATE
  } cell_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_POP_REAR
  } state_e;

endpackage

`default_nettype wire

// File: src/dqe_if.sv
// Request and response channel interfaces for the double-ended queue.
`default_nettype none

interface dqe_req_if;
  logic                              valid;
  logic                              ready;
  logic        [dqe_pkg::REQ_W-1:0]  req_type;
  logic signed [dqe_pkg::WORD_W-1:0] push_value;

  modport source (output valid, output req_type, output push_value, input ready);
  modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface dqe_rsp_if;
  logic                                valid;
  logic                                ready;
  logic        [dqe_pkg::STATUS_W-1:0] status;
  logic signed [dqe_pkg::WORD_W-1:0]   word_out;
  logic                                last_of_run;
  logic        [dqe_pkg::FILL_W-1:0]   fill_count;

  modport source (output valid, output status, output word_out, output last_of_run,
                  output fill_count, input ready);
  modport sink   (input valid, input status, input word_out, input last_of_run,
                  input fill_count, output ready);
endinterface

`default_nettype wire

// File: src/dqe_cell.sv
// One storage cell of the queue chain: holds one word and takes it from a neighbor, the push input or the first cell.
`default_nettype none

module dqe_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 5
) (
  input  wire                              clk_i,
  input  dqe_pkg::cell_cmd_e               cmd_i,
  input  wire  [CNT_W-1:0]                 count_i,
  input  wire  [dqe_pkg::WORD_W-1:0]       prev_i,
  input  wire  [dqe_pkg::WORD_W-1:0]       next_i,
  input  wire  [dqe_pkg::WORD_W-1:0]       head_i,
  input  wire  [dqe_pkg::WORD_W-1:0]       push_i,
  output logic [dqe_pkg::WORD_W-1:0]       data_o
);

  logic [dqe_pkg::WORD_W-1:0] data_q, data_d;
  logic                       at_count;
  logic                       at_tail;

  assign at_count = (count_i == CNT_W'(IDX));
  assign at_tail  = (count_i == CNT_W'(IDX + 1));

  always_comb begin
    data_d = data_q;
    case (cmd_i)
      dqe_pkg::CMD_SHIFT_IN:  data_d = prev_i;
      dqe_pkg::CMD_LOAD_REAR: if (at_count) data_d = push_i;
      dqe_pkg::CMD_ROTATE:    data_d = at_tail ? head_i : next_i;
      default:                data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: src/double_ended_queue.sv
// Double-ended queue top level: cell chain, request sequencer and response register.
// The queue holds up to DEPTH signed words in a chain of cells, front word in the first
// cell. Push front, push rear and pop front keep the sequencer idle, so one such request
// is taken per cycle while responses are consumed. Pop rear and read out walk the chain:
// it rotates one place per cycle, holding where a response cannot yet be given, until
// the wanted word reaches the first cell, and a full read out rotates the chain once
// around, which leaves the order unchanged. A refused push, an empty pop and an unknown
// request likewise keep the sequencer idle. No clearing pass follows reset.
`default_nettype none

module double_ended_queue #(
  parameter int unsigned DEPTH = 16
) (
  input wire          clk_i,
  input wire          rst_ni,
  dqe_req_if.sink     req_i,
  dqe_rsp_if.source   rsp_o
);

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WALK_W = $clog2(DEPTH);

  dqe_pkg::state_e     state_q, state_d;
  dqe_pkg::cell_cmd_e  cmd;
  dqe_pkg::req_e       req;

  logic [CNT_W-1:0]    count_q, count_d;
  logic [WALK_W-1:0]   walk_q, walk_d;

  logic                           out_valid_q, out_valid_d;
  dqe_pkg::status_e               out_status_q, out_status_d;
  logic [dqe_pkg::WORD_W-1:0]     out_word_q, out_word_d;
  logic                           out_last_q, out_last_d;
  logic [dqe_pkg::FILL_W-1:0]     out_fill_q, out_fill_d;

  logic [dqe_pkg::WORD_W-1:0]     cell_data [DEPTH];
  logic                           slot_free;
  logic                           accept;
  logic                           is_full;
  logic                           is_empty;

  assign req       = dqe_pkg::req_e'(req_i.req_type);
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == dqe_pkg::ST_IDLE) && slot_free;
  assign accept    = req_i.valid && req_i.ready;
  assign is_full   = (count_q == CNT_W'(DEPTH));
  assign is_empty  = (count_q == '0);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [dqe_pkg::WORD_W-1:0] prev;
    logic [dqe_pkg::WORD_W-1:0] next;

    if (i == 0) begin : g_first
      assign prev = req_i.push_value;
    end else begin : g_mid_prev
      assign prev = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next = cell_data[0];
    end else begin : g_mid_next
      assign next = cell_data[i+1];
    end

    dqe_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .count_i (count_q),
      .prev_i  (prev),
      .next_i  (next),
      .head_i  (cell_data[0]),
      .push_i  (req_i.push_value),
      .data_o  (cell_data[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dqe_pkg::ST_IDLE: begin
        if (accept && !is_empty) begin
          if (req == dqe_pkg::REQ_READ_ALL) begin
            state_d = dqe_pkg::ST_READ;
          end else if (req == dqe_pkg::REQ_POP_REAR && count_q != CNT_W'(1)) begin
            state_d = dqe_pkg::ST_POP_REAR;
          end
        end
      end
      dqe_pkg::ST_READ: begin
        if (slot_free && walk_q == '0) state_d = dqe_pkg::ST_IDLE;
      end
      dqe_pkg::ST_POP_REAR: begin
        if (slot_free && walk_q == '0) state_d = dqe_pkg::ST_IDLE;
      end
      default: state_d = dqe_pkg::ST_IDLE;
    endcase
  end

  // chain commands, counters and response
  always_comb begin
    cmd          = dqe_pkg::CMD_HOLD;
    count_d      = count_q;
    walk_d       = walk_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    out_fill_d   = out_fill_q;

    unique case (state_q)
      dqe_pkg::ST_IDLE: begin
        if (accept) begin
          out_valid_d  = 1'b1;
          out_status_d = dqe_pkg::STATUS_OK;
          out_word_d   = '0;
          out_last_d   = 1'b1;
          out_fill_d   = dqe_pkg::FILL_W'(count_q);
          unique case (req) inside
            dqe_pkg::REQ_PUSH_FRONT, dqe_pkg::REQ_PUSH_REAR: begin
              if (is_full) begin
                out_status_d = dqe_pkg::STATUS_FULL;
              end else begin
                cmd        = (req == dqe_pkg::REQ_PUSH_FRONT) ? dqe_pkg::CMD_SHIFT_IN
                                                              : dqe_pkg::CMD_LOAD_REAR;
                count_d    = count_q + 1'b1;
                out_fill_d = dqe_pkg::FILL_W'(count_d);
              end
            end
            dqe_pkg::REQ_POP_FRONT, dqe_pkg::REQ_POP_REAR: begin
              if (is_empty) begin
                out_status_d = dqe_pkg::STATUS_EMPTY;
              end else if (req == dqe_pkg::REQ_POP_FRONT || count_q == CNT_W'(1)) begin
                cmd        = dqe_pkg::CMD_ROTATE;
                count_d    = count_q - 1'b1;
                out_word_d = cell_data[0];
                out_fill_d = dqe_pkg::FILL_W'(count_d);
              end else begin
                // rotate until the rear word reaches the first cell
                cmd         = dqe_pkg::CMD_ROTATE;
                walk_d      = WALK_W'(count_q - CNT_W'(2));
                out_valid_d = out_valid_q && !rsp_o.ready;
              end
            end
            dqe_pkg::REQ_READ_ALL: begin
              if (is_empty) begin
                out_status_d = dqe_pkg::STATUS_EMPTY;
              end else begin
                walk_d      = WALK_W'(count_q - 1'b1);
                out_valid_d = out_valid_q && !rsp_o.ready;
              end
            end
            default: ;
          endcase
        end
      end
      dqe_pkg::ST_READ: begin
        if (slot_free) begin
          cmd          = dqe_pkg::CMD_ROTATE;
          out_valid_d  = 1'b1;
          out_status_d = dqe_pkg::STATUS_OK;
          out_word_d   = cell_data[0];
          out_last_d   = (walk_q == '0);
          out_fill_d   = dqe_pkg::FILL_W'(count_q);
          if (walk_q != '0) walk_d = walk_q - 1'b1;
        end
      end
      dqe_pkg::ST_POP_REAR: begin
        if (walk_q != '0) begin
          cmd    = dqe_pkg::CMD_ROTATE;
          walk_d = walk_q - 1'b1;
        end else if (slot_free) begin
          cmd          = dqe_pkg::CMD_ROTATE;
          count_d      = count_q - 1'b1;
          out_valid_d  = 1'b1;
          out_status_d = dqe_pkg::STATUS_OK;
          out_word_d   = cell_data[0];
          out_last_d   = 1'b1;
          out_fill_d   = dqe_pkg::FILL_W'(count_d);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dqe_pkg::ST_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_word_q   <= out_word_d;
    out_last_q   <= out_last_d;
    out_fill_q   <= out_fill_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.word_out    = out_word_q;
  assign rsp_o.last_of_run = out_last_q;
  assign rsp_o.fill_count  = out_fill_q;

endmodule

`default_nettype wire

// File: src/dqe_checker.sv
// Port-level assertions for the double-ended queue, bound to the top level.
`default_nettype none

module dqe_assert #(
  parameter int unsigned DEPTH = 16
) (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               in_ready_i,
  input wire                               out_valid_i,
  input wire                               out_ready_i,
  input wire [dqe_pkg::STATUS_W-1:0]       status_i,
  input wire [dqe_pkg::WORD_W-1:0]         word_out_i,
  input wire                               last_of_run_i,
  input wire [dqe_pkg::FILL_W-1:0]         fill_count_i
);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (32'(fill_count_i) <= DEPTH))
    else $error("fill count above depth");

  a_refusal_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i != dqe_pkg::STATUS_OK) |-> (word_out_i == '0 && last_of_run_i))
    else $error("refused or empty request gave a word or a multi-part response");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && status_i == dqe_pkg::STATUS_FULL) |->
      (fill_count_i == dqe_pkg::FILL_W'(DEPTH)))
    else $error("full status with room left");

  a_no_request_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_of_run_i) |-> !in_ready_i)
    else $error("new request taken during a read out");

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(word_out_i) && $stable(status_i)))
    else $error("stalled response changed");

endmodule

bind double_ended_queue dqe_assert #(
  .DEPTH (DEPTH)
) u_dqe_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .word_out_i    (rsp_o.word_out),
  .last_of_run_i (rsp_o.last_of_run),
  .fill_count_i  (rsp_o.fill_count)
);

`default_nettype wire

// File: verif/dqe_checker.sv
// Request/result monitor and reference predictor for the double-ended queue.
`default_nettype none

module dqe_checker
  import dqe_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input wire   clk_i,
  input wire   rst_ni,
  dqe_req_if   req_i,
  dqe_rsp_if   rsp_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   request_count_o,
  output int   result_count_o
);

  typedef struct packed {
    status_e                    status;
    logic signed [WORD_W-1:0]   word;
    logic                       last;
    logic        [FILL_W-1:0]   fill;
  } dqe_result_t;

  logic signed [WORD_W-1:0] ring_words [DEPTH];
  int unsigned              front_idx;
  int unsigned              held;
  dqe_result_t              expected_results [$];
  int                       fails;
  int                       requests;
  int                       results;

  function automatic void queue_result(status_e status, logic signed [WORD_W-1:0] word,
                                       logic last);
    dqe_result_t res;
    res.status = status;
    res.word   = word;
    res.last   = last;
    res.fill   = FILL_W'(held);
    expected_results.push_back(res);
  endfunction

  function automatic void predict_request(logic [REQ_W-1:0] kind,
                                          logic signed [WORD_W-1:0] value);
    case (kind)
      REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
        if (held >= DEPTH) begin
          queue_result(STATUS_FULL, '0, 1'b1);
        end else begin
          if (kind == REQ_PUSH_FRONT) begin
            front_idx = (front_idx + DEPTH - 1) % DEPTH;
            ring_words[front_idx] = value;
          end else begin
            ring_words[(front_idx + held) % DEPTH] = value;
          end
          held++;
          queue_result(STATUS_OK, '0, 1'b1);
        end
      end
      REQ_POP_FRONT, REQ_POP_REAR: begin
        if (held == 0) begin
          queue_result(STATUS_EMPTY, '0, 1'b1);
        end else if (kind == REQ_POP_FRONT) begin
          held--;
          queue_result(STATUS_OK, ring_words[front_idx], 1'b1);
          front_idx = (front_idx + 1) % DEPTH;
        end else begin
          held--;
          queue_result(STATUS_OK, ring_words[(front_idx + held) % DEPTH], 1'b1);
        end
      end
      REQ_READ_ALL: begin
        if (held == 0) begin
          queue_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < held; i++) begin
            queue_result(STATUS_OK, ring_words[(front_idx + i) % DEPTH], i + 1 == held);
          end
        end
      end
      default: begin
        queue_result(STATUS_OK, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_result(logic [STATUS_W-1:0] status,
                                       logic signed [WORD_W-1:0] word,
                                       logic last, logic [FILL_W-1:0] fill);
    dqe_result_t want;
    if (expected_results.size() == 0) begin
      $error("unexpected result: status %0d, word_out %0d", status, word);
      fails++;
      return;
    end
    want = expected_results.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      fails++;
    end
    if (word !== want.word) begin
      $error("word_out: expected %0d, got %0d", want.word, word);
      fails++;
    end
    if (last !== want.last) begin
      $error("last_of_run: expected %0d, got %0d", want.last, last);
      fails++;
    end
    if (fill !== want.fill) begin
      $error("fill_count: expected %0d, got %0d", want.fill, fill);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_idx = 0;
      held      = 0;
      fails     = 0;
      requests  = 0;
      results   = 0;
      expected_results.delete();
    end else begin
      if (req_i.valid && req_i.ready) begin
        predict_request(req_i.req_type, req_i.push_value);
        requests++;
      end
      if (rsp_i.valid && rsp_i.ready) begin
        check_result(rsp_i.status, rsp_i.word_out, rsp_i.last_of_run, rsp_i.fill_count);
        results++;
      end
    end
    fail_count_o    <= fails;
    pending_o       <= expected_results.size();
    request_count_o <= requests;
    result_count_o  <= results;
  end

endmodule

`default_nettype wire

// File: verif/tb.sv
// Testbench top: clock, reset, request and result traffic, watchdog and verdict.
`default_nettype none

module tb;
  import dqe_pkg::*;

  localparam int unsigned     DEPTH          = 16;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;
  localparam int              RANDOM_ITEMS   = 75;
  localparam int              HOLD_AFTER     = 40;
  localparam int              HOLD_CYCLES    = 120;
  localparam int              DRAIN_CYCLES   = 40;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   request_count;
  int   result_count;
  int   send_streak;
  bit   send_quiet;
  int   recv_streak;
  bit   recv_quiet;
  int   idle_cycles;

  dqe_req_if req ();
  dqe_rsp_if rsp ();

  double_ended_queue #(.DEPTH(DEPTH)) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  dqe_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_i           (req),
    .rsp_i           (rsp),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .request_count_o (request_count),
    .result_count_o  (result_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Alternate stretches of random gaps with stretches of back-to-back traffic.
  function automatic int draw_gap(ref int streak, ref bit quiet);
    if (streak == 0) begin
      streak = $urandom_range(5, 15);
      quiet  = ($urandom_range(0, 2) == 0);
    end
    streak--;
    return quiet ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] kind,
                              input logic signed [WORD_W-1:0] value);
    int gap;
    gap = draw_gap(send_streak, send_quiet);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.push_value <= value;
    do @(posedge clk); while (!req.ready);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("no request or result moved for %0d cycles", idle_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold so the queue backs up.
  initial begin
    int gap;
    int taken;
    taken       = 0;
    recv_streak = 0;
    rsp.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(recv_streak, recv_quiet);
      if (taken == HOLD_AFTER) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      taken++;
    end
  end

  initial begin
    int          pick;
    bit          fill_bias;
    logic [REQ_W-1:0] kind;
    send_streak = 0;
    idle_cycles = 0;
    fill_bias   = 1'b0;
    rst_n          <= 1'b0;
    req.valid      <= 1'b0;
    req.req_type   <= REQ_PUSH_FRONT;
    req.push_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(REQ_POP_FRONT, $urandom);
    send_request(REQ_POP_REAR, $urandom);
    send_request(REQ_READ_ALL, $urandom);
    send_request(REQ_UNKNOWN_LO, $urandom);
    send_request(REQ_UNKNOWN_HI, $urandom);
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:       send_request(REQ_PUSH_FRONT, WORD_MIN);
        1:       send_request(REQ_PUSH_REAR, WORD_MAX);
        2:       send_request(REQ_PUSH_FRONT, '0);
        3:       send_request(REQ_PUSH_REAR, -1);
        default: send_request(i[0] ? REQ_PUSH_REAR : REQ_PUSH_FRONT, $urandom);
      endcase
    end
    send_request(REQ_PUSH_FRONT, $urandom);
    send_request(REQ_PUSH_REAR, $urandom);
    send_request(REQ_READ_ALL, $urandom);
    send_request(REQ_POP_FRONT, $urandom);
    send_request(REQ_POP_REAR, $urandom);

    // Swing between filling and draining so both full and empty get hit.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 20 == 0) begin
        fill_bias = !fill_bias;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        kind = REQ_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
      end else if (pick < 12) begin
        kind = REQ_READ_ALL;
      end else if (pick < 56) begin
        kind = fill_bias ? ($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR)
                         : ($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR);
      end else if (pick < 78) begin
        kind = fill_bias ? REQ_PUSH_REAR : REQ_POP_FRONT;
      end else begin
        kind = fill_bias ? ($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR)
                         : ($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR);
      end
      send_request(kind, pick_word());
    end
    req.valid <= 1'b0;

    // let the checker count the last request before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending != 0) begin
      $error("%0d expected results never arrived", pending);
    end
    $display("Sent %0d requests (pushes, pops, read-outs, unknown codes), checked %0d results,",
             request_count, result_count);
    $display("with the queue driven through empty and full and one long result-side hold.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
